>>> sv/hsvk_pkg.sv
`default_nettype none

package hsvk_pkg;

	localparam int ByteW = 8;
	localparam int QW = 13;
	localparam int OpW = 11;
	localparam int DivSteps = QW;
	localparam int AddrW = 5;
	localparam int DataW = 32;

	localparam logic [QW-1:0] QOne = QW'(4096);

	typedef enum logic [2:0] {
		REG_HUE_LOW,
		REG_HUE_HIGH,
		REG_SAT_LOW,
		REG_SAT_HIGH,
		REG_VAL_LOW,
		REG_VAL_HIGH,
		REG_OUTPUT_SAT,
		REG_SWAP_ORDER
	} reg_idx_t;

	typedef struct packed {
		logic [ByteW-1:0] chan_first;
		logic [ByteW-1:0] chan_green;
		logic [ByteW-1:0] chan_last;
	} pixel_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             in_window;
		logic [QW-1:0]    hue_q;
		logic [QW-1:0]    sat_q;
		logic [QW-1:0]    val_q;
	} result_t;

	typedef struct packed {
		logic [OpW-1:0] num;
		logic [OpW-1:0] den;
	} div_op_t;

	typedef struct packed {
		div_op_t       hue;
		div_op_t       sat;
		logic [QW-1:0] val;
	} front_t;

	typedef struct packed {
		logic [QW-1:0] hue_low;
		logic [QW-1:0] hue_high;
		logic [QW-1:0] sat_low;
		logic [QW-1:0] sat_high;
		logic [QW-1:0] val_low;
		logic [QW-1:0] val_high;
		logic          output_saturation;
		logic          swap_order;
	} cfg_t;

endpackage

`default_nettype wire

>>> sv/hsv_window_pixel_keyer.sv
// Color keyer: each pixel request is converted to HSV in Q12 (4096 is 1.0),
// tested against inclusive hue, saturation and value windows, and answered
// with one result request. One pixel is taken every clock while the
// pipeline is not held. A pixel passes through one front stage, the
// 13-stage restoring dividers that form hue and saturation one quotient bit
// per stage while the value from the front stage rides alongside, and the
// window stage. The whole pipeline holds while a result is stalled, so
// pix_stall follows res_valid && res_stall.
// Registers sit at byte addresses 4*i of the APB port; write them only
// while no pixels are in flight.
`default_nettype none

module hsv_window_pixel_keyer (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire [hsvk_pkg::AddrW-1:0]       paddr,
	input  wire [hsvk_pkg::DataW-1:0]       pwdata,
	output logic [hsvk_pkg::DataW-1:0]      prdata,
	output logic                            pready,
	input  wire                             pix_valid,
	output logic                            pix_stall,
	input  var hsvk_pkg::pixel_t            pix,
	output logic                            res_valid,
	input  wire                             res_stall,
	output hsvk_pkg::result_t               res
);

	hsvk_pkg::cfg_t     cfg_q;
	hsvk_pkg::reg_idx_t reg_idx;
	hsvk_pkg::front_t   ops, ops_s1;
	hsvk_pkg::result_t  win_res, res_q;
	logic [hsvk_pkg::QW-1:0] hue_div, sat_div;
	logic [hsvk_pkg::QW-1:0] val_dly_s [hsvk_pkg::DivSteps];
	logic vld_s1;
	logic vld_div_s [hsvk_pkg::DivSteps];
	logic res_valid_q;
	logic adv;

	assign pready = 1'b1;
	assign reg_idx = hsvk_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_low <= hsvk_pkg::QW'(410);
			cfg_q.hue_high <= hsvk_pkg::QW'(2048);
			cfg_q.sat_low <= '0;
			cfg_q.sat_high <= hsvk_pkg::QOne;
			cfg_q.val_low <= '0;
			cfg_q.val_high <= hsvk_pkg::QOne;
			cfg_q.output_saturation <= 1'b1;
			cfg_q.swap_order <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				hsvk_pkg::REG_HUE_LOW: cfg_q.hue_low <= pwdata[hsvk_pkg::QW-1:0];
				hsvk_pkg::REG_HUE_HIGH: cfg_q.hue_high <= pwdata[hsvk_pkg::QW-1:0];
				hsvk_pkg::REG_SAT_LOW: cfg_q.sat_low <= pwdata[hsvk_pkg::QW-1:0];
				hsvk_pkg::REG_SAT_HIGH: cfg_q.sat_high <= pwdata[hsvk_pkg::QW-1:0];
				hsvk_pkg::REG_VAL_LOW: cfg_q.val_low <= pwdata[hsvk_pkg::QW-1:0];
				hsvk_pkg::REG_VAL_HIGH: cfg_q.val_high <= pwdata[hsvk_pkg::QW-1:0];
				hsvk_pkg::REG_OUTPUT_SAT: cfg_q.output_saturation <= pwdata[0];
				hsvk_pkg::REG_SWAP_ORDER: cfg_q.swap_order <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hsvk_pkg::REG_HUE_LOW: prdata = hsvk_pkg::DataW'(cfg_q.hue_low);
			hsvk_pkg::REG_HUE_HIGH: prdata = hsvk_pkg::DataW'(cfg_q.hue_high);
			hsvk_pkg::REG_SAT_LOW: prdata = hsvk_pkg::DataW'(cfg_q.sat_low);
			hsvk_pkg::REG_SAT_HIGH: prdata = hsvk_pkg::DataW'(cfg_q.sat_high);
			hsvk_pkg::REG_VAL_LOW: prdata = hsvk_pkg::DataW'(cfg_q.val_low);
			hsvk_pkg::REG_VAL_HIGH: prdata = hsvk_pkg::DataW'(cfg_q.val_high);
			hsvk_pkg::REG_OUTPUT_SAT: prdata = hsvk_pkg::DataW'(cfg_q.output_saturation);
			hsvk_pkg::REG_SWAP_ORDER: prdata = hsvk_pkg::DataW'(cfg_q.swap_order);
			default: prdata = '0;
		endcase
	end

	// whole pipeline moves unless a finished result is held
	assign adv = !res_valid_q || !res_stall;
	assign pix_stall = !adv;

	hsvk_front u_front (
		.pix        (pix),
		.swap_order (cfg_q.swap_order),
		.ops        (ops)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ops_s1 <= ops;
		end
	end

	hsvk_div u_div_hue (
		.clk (clk),
		.en  (adv),
		.op  (ops_s1.hue),
		.quo (hue_div)
	);

	hsvk_div u_div_sat (
		.clk (clk),
		.en  (adv),
		.op  (ops_s1.sat),
		.quo (sat_div)
	);

	// value keeps pace with the dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			val_dly_s[0] <= ops_s1.val;
			for (int i = 1; i < hsvk_pkg::DivSteps; i++) begin
				val_dly_s[i] <= val_dly_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < hsvk_pkg::DivSteps; i++) begin
				vld_div_s[i] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_valid;
			vld_div_s[0] <= vld_s1;
			for (int i = 1; i < hsvk_pkg::DivSteps; i++) begin
				vld_div_s[i] <= vld_div_s[i-1];
			end
			res_valid_q <= vld_div_s[hsvk_pkg::DivSteps-1];
		end
	end

	hsvk_window u_window (
		.hue (hue_div),
		.sat (sat_div),
		.val (val_dly_s[hsvk_pkg::DivSteps-1]),
		.cfg (cfg_q),
		.res (win_res)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= win_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.in_window |-> res.out_byte == '0)
		else $error("miss with nonzero output byte");

	a_q12_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.hue_q <= hsvk_pkg::QOne && res.sat_q <= hsvk_pkg::QOne &&
			res.val_q <= hsvk_pkg::QOne)
		else $error("hsv result above one");

	a_grey_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.sat_q == '0) == (res.hue_q == hsvk_pkg::QOne))
		else $error("grey hue and zero saturation disagree");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(ops_s1))
		else $error("front stage lost a request under stall");

endmodule

`default_nettype wire

>>> sv/hsvk_front.sv
`default_nettype none

module hsvk_front (
	input  var hsvk_pkg::pixel_t pix,
	input  wire                  swap_order,
	output hsvk_pkg::front_t     ops
);

	logic [hsvk_pkg::ByteW-1:0] r, g, b, mx, mn, d;
	logic [hsvk_pkg::OpW-1:0]   six_d, num;
	logic [hsvk_pkg::QW-2:0]    mx16;
	logic [hsvk_pkg::QW-1:0]    val_fix;
	logic                       r_max, g_max, grey;

	always_comb begin
		r = swap_order ? pix.chan_last : pix.chan_first;
		g = pix.chan_green;
		b = swap_order ? pix.chan_first : pix.chan_last;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		d = mx - mn;
		grey = (mx == mn);
		r_max = (r == mx);
		g_max = !r_max && (g == mx);
		six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
		// sextant hue scaled by d, wrapped into one positive turn
		if (r_max) begin
			if (g >= b) begin
				num = hsvk_pkg::OpW'(g - b);
			end else begin
				num = six_d - hsvk_pkg::OpW'(b - g);
			end
		end else if (g_max) begin
			num = {2'b00, d, 1'b0} + hsvk_pkg::OpW'(b) - hsvk_pkg::OpW'(r);
		end else begin
			num = {1'b0, d, 2'b00} + hsvk_pkg::OpW'(r) - hsvk_pkg::OpW'(g);
		end

		// grey divides 1 by 1 to give exactly one turn
		if (grey) begin
			ops.hue.num = hsvk_pkg::OpW'(1);
			ops.hue.den = hsvk_pkg::OpW'(1);
		end else begin
			ops.hue.num = num;
			ops.hue.den = six_d;
		end
		if (mx == '0) begin
			ops.sat.num = '0;
			ops.sat.den = hsvk_pkg::OpW'(1);
		end else begin
			ops.sat.num = hsvk_pkg::OpW'(d);
			ops.sat.den = hsvk_pkg::OpW'(mx);
		end

		// mx*4096/255 is mx*16 plus mx*16/255
		mx16 = {mx, 4'b0000};
		val_fix = hsvk_pkg::QW'(mx16) + hsvk_pkg::QW'(mx16[11:8]) + hsvk_pkg::QW'(1);
		ops.val = hsvk_pkg::QW'(mx16) + (val_fix >> 8);
	end

endmodule

`default_nettype wire

>>> sv/hsvk_div.sv
`default_nettype none

module hsvk_div (
	input  wire                       clk,
	input  wire                       en,
	input  var hsvk_pkg::div_op_t     op,
	output logic [hsvk_pkg::QW-1:0]   quo
);

	logic [hsvk_pkg::OpW-1:0] rem_s [hsvk_pkg::DivSteps];
	logic [hsvk_pkg::OpW-1:0] den_s [hsvk_pkg::DivSteps];
	logic [hsvk_pkg::QW-1:0]  quo_s [hsvk_pkg::DivSteps];

	// restoring division of num * 4096 by den, one quotient bit per stage
	for (genvar k = 0; k < hsvk_pkg::DivSteps; k++) begin : g_step
		logic [hsvk_pkg::OpW:0]   trial;
		logic [hsvk_pkg::OpW-1:0] den_in;
		logic [hsvk_pkg::QW-1:0]  quo_in;
		logic                     take;

		if (k == 0) begin : g_first
			assign trial = {1'b0, op.num};
			assign den_in = op.den;
			assign quo_in = '0;
		end else begin : g_next
			assign trial = {rem_s[k-1], 1'b0};
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign take = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? hsvk_pkg::OpW'(trial - {1'b0, den_in})
					: trial[hsvk_pkg::OpW-1:0];
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[hsvk_pkg::QW-2:0], take};
			end
		end
	end

	assign quo = quo_s[hsvk_pkg::DivSteps-1];

endmodule

`default_nettype wire

>>> sv/hsvk_window.sv
`default_nettype none

module hsvk_window (
	input  wire [hsvk_pkg::QW-1:0] hue,
	input  wire [hsvk_pkg::QW-1:0] sat,
	input  wire [hsvk_pkg::QW-1:0] val,
	input  var hsvk_pkg::cfg_t     cfg,
	output hsvk_pkg::result_t      res
);

	logic [hsvk_pkg::QW+7:0] sat_x255;
	logic                    hit;

	always_comb begin
		hit = (hue >= cfg.hue_low) && (hue <= cfg.hue_high) &&
			(sat >= cfg.sat_low) && (sat <= cfg.sat_high) &&
			(val >= cfg.val_low) && (val <= cfg.val_high);
		sat_x255 = {sat, 8'd0} - {8'd0, sat};
		res.hue_q = hue;
		res.sat_q = sat;
		res.val_q = val;
		res.in_window = hit;
		if (!hit) begin
			res.out_byte = '0;
		end else if (cfg.output_saturation) begin
			res.out_byte = sat_x255[19:12];
		end else begin
			res.out_byte = 8'hff;
		end
	end

endmodule

`default_nettype wire
